// File: sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the fit-policy block allocator
// Field widths, register indexes, policy and mode codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;

  localparam int SIZE_W     = 16;
  localparam int BIDX_W     = 4;
  localparam int POLICY_W   = 2;
  localparam int NBLK_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b1;

  localparam logic [NBLK_W-1:0] NUM_BLOCKS_RST = 5'd16;

  // placement policies, code three behaves as worst fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // input item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } fba_state_t;

endpackage

`default_nettype wire

// File: sv/fba_if.sv
// ----------------------------------------------------------------------------
// fba_if: valid/ready channels of the fit-policy block allocator
// Input channel carries load and request items, output channel the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [fba_pkg::BIDX_W-1:0]  block_index;
  logic [fba_pkg::SIZE_W-1:0]  size;

  modport source (output valid, mode, block_index, size, input ready);
  modport sink   (input valid, mode, block_index, size, output ready);
endinterface

interface fba_out_if;
  logic                        valid;
  logic                        ready;
  logic                        allocated;
  logic [fba_pkg::BIDX_W-1:0]  chosen_block;
  logic [fba_pkg::SIZE_W-1:0]  remaining;

  modport source (output valid, allocated, chosen_block, remaining, input ready);
  modport sink   (input valid, allocated, chosen_block, remaining, output ready);
endinterface

`default_nettype wire

// File: sv/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first / best / worst fit block allocator
// Holds free sizes of NUM_BLOCKS blocks in a memory; a request scans the
// active blocks one at a time and writes back the chosen block.
// ----------------------------------------------------------------------------
// a load writes its block and gives no result; a request scans
//   min(num_blocks, NUM_BLOCKS) blocks, one read per cycle, then fills the
//   output register; no new item is taken until that result is registered,
//   held while the output register is full; loads one per cycle while idle
// reset: synchronous; all free sizes read as zero, policy first fit,
//   num_blocks 16, output empty
`default_nettype none

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  fba_in_if.sink                                in_ch,
  fba_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import fba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > NBLK_W) ? CNT_W : NBLK_W;
  localparam int XW    = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;

  fba_state_t state, state_next;

  logic [POLICY_W-1:0] policy;
  logic [NBLK_W-1:0]   num_blocks;

  logic [SIZE_W-1:0]   mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_bits;

  logic [SIZE_W-1:0]   req;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    limit;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_idx;
  logic [SIZE_W-1:0]   rd_data;
  logic                rd_ok;
  logic                found;
  logic [IDX_W-1:0]    pick;
  logic [SIZE_W-1:0]   pick_free;

  logic                out_valid;
  logic                out_allocated;
  logic [BIDX_W-1:0]   out_chosen;
  logic [SIZE_W-1:0]   out_remaining;

  logic                in_ready;
  logic                in_acc;
  logic                load_ok;
  logic                issue;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [SIZE_W-1:0]   mem_wdata;
  logic [SIZE_W-1:0]   diff;
  logic [SIZE_W-1:0]   f;
  logic                fits;
  logic                take;
  logic                out_free;
  logic [XW-1:0]       pick_x;

  assign f        = rd_ok ? rd_data : '0;
  assign fits     = (f >= req);
  assign diff     = pick_free - req;
  assign out_free = !out_valid || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ready;
  assign load_ok  = (32'(in_ch.block_index) < NUM_BLOCKS);
  assign pick_x   = XW'(pick);

  always_comb begin
    case (policy) inside
      POL_FIRST: take = 1'b0;
      POL_BEST:  take = (f < pick_free);
      default:   take = (f > pick_free);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_ch.mode == MODE_REQ) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rd_pend) state_next = found ? S_WRITE : S_DONE;
      end
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(in_ch.block_index);
    mem_wdata = in_ch.size;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_acc && (in_ch.mode == MODE_LOAD) && load_ok;
      end
      S_SCAN: issue = (cnt != limit);
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pick;
        mem_wdata = diff;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign rd_addr = cnt[IDX_W-1:0];

  // free-size memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      policy     <= POL_FIRST;
      num_blocks <= NUM_BLOCKS_RST;
      valid_bits <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:     policy     <= cfg_data[POLICY_W-1:0];
          CFG_NUM_BLOCKS: num_blocks <= cfg_data;
          default: ;
        endcase
      end

      if (mem_we) valid_bits[mem_waddr] <= 1'b1;

      if (state == S_IDLE && in_acc && in_ch.mode == MODE_REQ) found <= 1'b0;
      else if (rd_pend && fits && (!found || take)) found <= 1'b1;

      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ok <= valid_bits[rd_addr];
    if (state == S_IDLE && in_acc) begin
      req   <= in_ch.size;
      cnt   <= '0;
      // active count saturates at the table depth
      limit <= (CMP_W'(num_blocks) > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                         : CNT_W'(num_blocks);
    end
    if (issue) begin
      cnt    <= cnt + CNT_W'(1);
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (rd_pend && fits && (!found || take)) begin
      pick      <= rd_idx;
      pick_free <= f;
    end
    if (state == S_WRITE) pick_free <= diff;
    if (state == S_DONE && out_free) begin
      out_allocated <= found;
      out_chosen    <= found ? pick_x[BIDX_W-1:0] : '0;
      out_remaining <= found ? pick_free : '0;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.allocated    = out_allocated;
  assign out_ch.chosen_block = out_chosen;
  assign out_ch.remaining    = out_remaining;

endmodule

`default_nettype wire

// File: sv/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker: port-level assertions for the fit-policy block allocator
// Watches the channel handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_mode,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_allocated,
  input wire logic [fba_pkg::BIDX_W-1:0]  out_chosen_block,
  input wire logic [fba_pkg::SIZE_W-1:0]  out_remaining
);

  import fba_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_allocated)
      && $stable(out_chosen_block) && $stable(out_remaining))
    else $error("result changed while stalled");

  // a request keeps the input closed while it scans
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == MODE_REQ |=> !in_ready)
    else $error("input ready right after a request");

  // a refused request reports zero block and zero remaining
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_allocated |-> out_chosen_block == '0 && out_remaining == '0)
    else $error("refused request with nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind fit_policy_block_allocator fba_checker u_fba_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_allocated    (out_ch.allocated),
  .out_chosen_block (out_ch.chosen_block),
  .out_remaining    (out_ch.remaining)
);

`default_nettype wire

// File: test/tb_fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator: self-checking bench for the block allocator
// Loads free sizes and sends allocation requests under first, best and worst
// fit and several block counts, predicts every grant and compares each result.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fba_pkg::*;

  localparam int NB          = NUM_BLOCKS_DEF;
  localparam int ITEM_GOAL   = 1850;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYC  = NB + 8;

  // code three is not named in the package, the block treats it as worst fit
  localparam logic [POLICY_W-1:0] POL_ALIAS_WORST = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [BIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] size;
  } alloc_item_t;

  typedef struct packed {
    logic              allocated;
    logic [BIDX_W-1:0] chosen_block;
    logic [SIZE_W-1:0] remaining;
  } grant_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fba_in_if  in_ch ();
  fba_out_if out_ch ();

  fit_policy_block_allocator #(.NUM_BLOCKS(NB)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SIZE_W-1:0]   free_size [NB];
  logic [POLICY_W-1:0] policy_cfg;
  logic [NBLK_W-1:0]   num_blocks_cfg;

  alloc_item_t pending_items [$];
  grant_t      expected_grants [$];

  // generator's rough view of loaded sizes, used to aim requests
  logic [SIZE_W-1:0] gen_free [NB];

  bit in_fire;
  bit bursty;
  int sink_mode;
  int burst_left, gap_left;
  logic [15:0] stall_pattern;
  logic [3:0]  pat_pos;
  alloc_item_t next_item;

  int errors, cycle_count;
  int items_queued, n_loads, n_requests, n_granted, n_refused, n_settings;

  function automatic grant_t predict_grant(input logic [SIZE_W-1:0] req);
    grant_t g;
    int lim, pick;
    bit found;
    g = '0;
    pick = 0;
    found = 1'b0;
    lim = (num_blocks_cfg > NB) ? NB : int'(num_blocks_cfg);
    for (int k = 0; k < lim; k++) begin
      if (free_size[k] >= req) begin
        if (!found) begin
          found = 1'b1;
          pick = k;
          if (policy_cfg == POL_FIRST) break;
        end else if (policy_cfg == POL_BEST) begin
          if (free_size[k] < free_size[pick]) pick = k;
        end else begin
          if (free_size[k] > free_size[pick]) pick = k;
        end
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - req;
      g.allocated = 1'b1;
      g.chosen_block = BIDX_W'(pick);
      g.remaining = free_size[pick];
    end
    return g;
  endfunction

  function automatic void queue_item(input logic m, input logic [BIDX_W-1:0] bi,
                                     input logic [SIZE_W-1:0] sz);
    alloc_item_t it;
    it.mode = m;
    it.block_index = bi;
    it.size = sz;
    pending_items.push_back(it);
    if (m == MODE_LOAD) gen_free[bi] = sz;
    items_queued++;
  endfunction

  // block loads for the active range, then requests mixed with loads and noise
  task automatic queue_phase(input int n_req);
    int lim, roll;
    logic [BIDX_W-1:0] bi;
    logic [SIZE_W-1:0] sz;
    lim = (num_blocks_cfg > NB) ? NB : int'(num_blocks_cfg);
    for (int k = 0; k < lim; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        roll = $urandom_range(0, 9);
        if (roll < 4) sz = 16'($urandom);
        else if (roll < 8) sz = 16'($urandom_range(1, 1000));
        else sz = gen_free[$urandom_range(0, NB - 1)];
        queue_item(MODE_LOAD, BIDX_W'(k), sz);
      end
    end
    for (int n = 0; n < n_req; n++) begin
      roll = $urandom_range(0, 19);
      bi = BIDX_W'($urandom);
      if (roll < 2) begin
        queue_item(1'($urandom), bi, 16'($urandom));
      end else if (roll < 5) begin
        queue_item(MODE_LOAD, bi, (roll == 2) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
      end else begin
        if (roll < 9) sz = gen_free[$urandom_range(0, NB - 1)];
        else if (roll < 13) sz = gen_free[$urandom_range(0, NB - 1)] >> 1;
        else if (roll < 16) sz = 16'($urandom_range(0, 31));
        else if (roll < 17) sz = '0;
        else sz = 16'($urandom_range(0, 4000));
        queue_item(MODE_REQ, bi, sz);
      end
    end
  endtask

  // wait until the block is idle: nothing left to send, nothing outstanding
  task automatic settle();
    while (pending_items.size() != 0 || in_ch.valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                           input logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= rdata;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (ridx == CFG_POLICY) policy_cfg = rdata[POLICY_W-1:0];
    else num_blocks_cfg = rdata;
    n_settings++;
  endtask

  // driver: one transaction presented at a time, bursts and gaps
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold until taken
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (pending_items.size() != 0) begin
      next_item = pending_items.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.mode <= next_item.mode;
      in_ch.block_index <= next_item.block_index;
      in_ch.size <= next_item.size;
      if (bursty) begin
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 10);
          gap_left = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result sink with its own stall pattern
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (sink_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_pattern[pat_pos];
        default: out_ch.ready <= (pat_pos[2:0] == 3'd0);
      endcase
      if (pat_pos == 4'hF) stall_pattern = 16'($urandom) | 16'h0101;
      pat_pos = pat_pos + 4'd1;
    end
  end

  // monitor: predict on accepted input, check on accepted result
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        if (in_ch.mode == MODE_LOAD) begin
          free_size[in_ch.block_index] = in_ch.size;
          n_loads++;
        end else begin
          expected_grants.push_back(predict_grant(in_ch.size));
          n_requests++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.allocated) n_granted++;
        else n_refused++;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result allocated=%0d block=%0d remaining=%0d", $time,
                   out_ch.allocated, out_ch.chosen_block, out_ch.remaining);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (out_ch.allocated !== want.allocated) begin
            $display("%0t: allocated expected %0d actual %0d", $time,
                     want.allocated, out_ch.allocated);
            errors++;
          end
          if (out_ch.chosen_block !== want.chosen_block) begin
            $display("%0t: chosen_block expected %0d actual %0d", $time,
                     want.chosen_block, out_ch.chosen_block);
            errors++;
          end
          if (out_ch.remaining !== want.remaining) begin
            $display("%0t: remaining expected %0d actual %0d", $time,
                     want.remaining, out_ch.remaining);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator test failed");
      $finish;
    end
  end

  initial begin
    logic [POLICY_W-1:0] pol;
    logic [NBLK_W-1:0]   count;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.block_index = '0;
    in_ch.size = '0;
    out_ch.ready = 1'b0;
    stall_pattern = 16'h5B6D;
    pat_pos = '0;
    bursty = 1'b1;
    sink_mode = 1;
    for (int k = 0; k < NB; k++) begin
      free_size[k] = '0;
      gen_free[k] = '0;
    end
    policy_cfg = POL_FIRST;
    num_blocks_cfg = NUM_BLOCKS_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset table is all zero: a zero request fits block 0, anything else fails
    queue_item(MODE_REQ, 4'h0, 16'd0);
    queue_item(MODE_REQ, 4'hF, 16'd1);
    queue_item(MODE_LOAD, 4'd0, 16'hFFFF);
    queue_item(MODE_LOAD, 4'd15, 16'hFFFF);
    queue_item(MODE_LOAD, 4'd5, 16'd100);
    queue_item(MODE_LOAD, 4'd7, 16'd100);
    queue_item(MODE_LOAD, 4'd3, 16'd50);
    queue_item(MODE_REQ, 4'd0, 16'd60);
    queue_item(MODE_REQ, 4'd0, 16'hFFFF);
    queue_item(MODE_REQ, 4'd0, 16'd100);
    settle();
    write_reg(CFG_POLICY, {3'b000, POL_BEST});
    queue_item(MODE_REQ, 4'd0, 16'd40);
    queue_item(MODE_REQ, 4'd0, 16'd100);   // tie between blocks 5 and 7
    settle();
    sink_mode = 0;
    write_reg(CFG_POLICY, {3'b111, POL_WORST});
    queue_item(MODE_REQ, 4'd0, 16'd1);
    settle();
    write_reg(CFG_POLICY, {3'b000, POL_ALIAS_WORST});
    queue_item(MODE_REQ, 4'd0, 16'd1);
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd0);
    queue_item(MODE_REQ, 4'd0, 16'd0);
    queue_item(MODE_LOAD, 4'd9, 16'd7);    // outside the active count, still kept
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd31);
    write_reg(CFG_POLICY, {3'b000, POL_FIRST});
    queue_item(MODE_REQ, 4'd0, 16'd7);
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd1);
    queue_item(MODE_REQ, 4'd0, 16'd7);

    while (items_queued < ITEM_GOAL) begin
      settle();
      pol = POLICY_W'($urandom_range(0, 3));
      write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), pol});
      case ($urandom_range(0, 9))
        0: count = 5'd0;
        1: count = 5'd1;
        2: count = 5'd16;
        3: count = 5'd31;
        4: count = NBLK_W'($urandom_range(17, 30));
        default: count = NBLK_W'($urandom_range(2, 16));
      endcase
      write_reg(CFG_NUM_BLOCKS, count);
      bursty = ($urandom_range(0, 3) != 0);
      sink_mode = $urandom_range(0, 2);
      queue_phase($urandom_range(20, 60));
    end

    settle();
    $display("sent %0d loads and %0d requests across %0d register writes",
             n_loads, n_requests, n_settings);
    $display("results seen: %0d granted, %0d not allocated", n_granted, n_refused);
    if (errors == 0) begin
      $display("fit_policy_block_allocator test passed");
    end else begin
      $display("fit_policy_block_allocator test failed");
    end
    $finish;
  end

endmodule
